@@ rtl/core/scbp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scbp_pkg
// shared types and constants of the size-class buffer pool
// ----------------------------------------------------------------------------
package scbp_pkg;

  localparam int NUM_CLASSES_DEF     = 6;
  localparam int SLOTS_PER_CLASS_DEF = 16;
  localparam int SIZE_BITS_DEF       = 16;

  localparam int SIZE_REGS  = 6;
  localparam int COUNT_BITS = 5;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 30;
  localparam int REQ_W      = 16;
  localparam int HANDLE_W   = 7;
  localparam int STATUS_W   = 2;

  localparam logic [CFG_IDX_W-1:0]  REG_COUNTS   = 3'd6;
  localparam logic [CFG_DATA_W-1:0] COUNTS_RESET = 30'd172235077;
  localparam logic [REQ_W-1:0] SIZE_RESET [SIZE_REGS] = '{
    16'd50, 16'd100, 16'd200, 16'd300, 16'd500, 16'd1024
  };

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 2'd0,
    ST_TOO_LARGE  = 2'd1,
    ST_NO_FREE    = 2'd2,
    ST_BAD_HANDLE = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FIND,
    S_ALLOC,
    S_FREE,
    S_RESULT
  } seq_state_t;

  typedef struct packed {
    logic clr;
    logic set;
  } map_op_t;

endpackage

@@ rtl/core/scbp_cfg_regs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scbp_cfg_regs
// class size and slot count registers, read out one class at a time
// ----------------------------------------------------------------------------
module scbp_cfg_regs import scbp_pkg::*; #(
  parameter int NUM_CLASSES     = NUM_CLASSES_DEF,
  parameter int SLOTS_PER_CLASS = SLOTS_PER_CLASS_DEF,
  parameter int SIZE_W          = SIZE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                wr_en,
  input  logic [CFG_IDX_W-1:0]                wr_index,
  input  logic [CFG_DATA_W-1:0]               wr_data,
  input  logic [(NUM_CLASSES > 1 ? $clog2(NUM_CLASSES) : 1)-1:0] rd_class,
  output logic [SIZE_W-1:0]                   class_size,
  output logic [$clog2(SLOTS_PER_CLASS+1)-1:0] class_slots
);

  localparam int CLS_W = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int CNT_W = $clog2(SLOTS_PER_CLASS + 1);

  logic [SIZE_W-1:0]     size_q [SIZE_REGS];
  logic [CFG_DATA_W-1:0] counts_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SIZE_REGS; i++) begin
        size_q[i] <= SIZE_W'(SIZE_RESET[i]);
      end
      counts_q <= COUNTS_RESET;
    end else if (wr_en) begin
      if (wr_index < CFG_IDX_W'(SIZE_REGS)) begin
        size_q[wr_index] <= wr_data[SIZE_W-1:0];
      end else if (wr_index == REG_COUNTS) begin
        counts_q <= wr_data;
      end
    end
  end

  // classes without a register have size 0 and no slots
  always_comb begin
    logic [COUNT_BITS-1:0] field;
    field       = '0;
    class_size  = '0;
    class_slots = '0;
    for (int i = 0; i < SIZE_REGS; i++) begin
      if (i < NUM_CLASSES && rd_class == CLS_W'(i)) begin
        field      = counts_q[COUNT_BITS*i +: COUNT_BITS];
        class_size = size_q[i];
        if ({1'b0, field} > (COUNT_BITS+1)'(SLOTS_PER_CLASS)) begin
          class_slots = CNT_W'(SLOTS_PER_CLASS);
        end else begin
          class_slots = CNT_W'(field);
        end
      end
    end
  end

endmodule

@@ rtl/core/scbp_slot_map.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scbp_slot_map
// per-class free bitmap with lowest-free-slot pick for the selected class
// ----------------------------------------------------------------------------
module scbp_slot_map import scbp_pkg::*; #(
  parameter int NUM_CLASSES     = NUM_CLASSES_DEF,
  parameter int SLOTS_PER_CLASS = SLOTS_PER_CLASS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [(NUM_CLASSES > 1 ? $clog2(NUM_CLASSES) : 1)-1:0] rd_class,
  input  logic [$clog2(SLOTS_PER_CLASS+1)-1:0] class_slots,
  input  map_op_t                             op,
  input  logic [(SLOTS_PER_CLASS > 1 ? $clog2(SLOTS_PER_CLASS) : 1)-1:0] wr_slot,
  output logic                                found,
  output logic [(SLOTS_PER_CLASS > 1 ? $clog2(SLOTS_PER_CLASS) : 1)-1:0] pick
);

  localparam int CLS_W  = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int SLOT_W = (SLOTS_PER_CLASS > 1) ? $clog2(SLOTS_PER_CLASS) : 1;
  localparam int CNT_W  = $clog2(SLOTS_PER_CLASS + 1);

  logic [SLOTS_PER_CLASS-1:0] map_q [NUM_CLASSES];
  logic [SLOTS_PER_CLASS-1:0] row;
  logic [SLOTS_PER_CLASS-1:0] avail;

  always_comb begin
    row = '0;
    for (int i = 0; i < NUM_CLASSES; i++) begin
      if (rd_class == CLS_W'(i)) begin
        row = map_q[i];
      end
    end
    for (int j = 0; j < SLOTS_PER_CLASS; j++) begin
      avail[j] = row[j] && (CNT_W'(j) < class_slots);
    end
    found = |avail;
    pick  = '0;
    for (int j = SLOTS_PER_CLASS - 1; j >= 0; j--) begin
      if (avail[j]) begin
        pick = SLOT_W'(j);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CLASSES; i++) begin
        map_q[i] <= '1;
      end
    end else begin
      for (int i = 0; i < NUM_CLASSES; i++) begin
        if (rd_class == CLS_W'(i)) begin
          if (op.clr) begin
            map_q[i][wr_slot] <= 1'b0;
          end else if (op.set) begin
            map_q[i][wr_slot] <= 1'b1;
          end
        end
      end
    end
  end

endmodule

@@ rtl/core/scbp_seq.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scbp_seq
// sequencer stepping one class per cycle through a shared compare/subtract
// ----------------------------------------------------------------------------
module scbp_seq import scbp_pkg::*; #(
  parameter int NUM_CLASSES     = NUM_CLASSES_DEF,
  parameter int SLOTS_PER_CLASS = SLOTS_PER_CLASS_DEF,
  parameter int SIZE_W          = SIZE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                cmd,
  input  logic [REQ_W-1:0]                    req_size,
  input  logic [HANDLE_W-1:0]                 free_handle,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [HANDLE_W-1:0]                 buffer_handle,
  output logic [STATUS_W-1:0]                 status,
  output logic [(NUM_CLASSES > 1 ? $clog2(NUM_CLASSES) : 1)-1:0] rd_class,
  input  logic [SIZE_W-1:0]                   class_size,
  input  logic [$clog2(SLOTS_PER_CLASS+1)-1:0] class_slots,
  input  logic                                found,
  input  logic [(SLOTS_PER_CLASS > 1 ? $clog2(SLOTS_PER_CLASS) : 1)-1:0] pick,
  output map_op_t                             map_op,
  output logic [(SLOTS_PER_CLASS > 1 ? $clog2(SLOTS_PER_CLASS) : 1)-1:0] wr_slot
);

  localparam int CLS_W  = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int SLOT_W = (SLOTS_PER_CLASS > 1) ? $clog2(SLOTS_PER_CLASS) : 1;
  localparam int BW     = $clog2(NUM_CLASSES * SLOTS_PER_CLASS + 1);
  localparam int DW     = (BW > HANDLE_W) ? BW : HANDLE_W;

  seq_state_t           state, state_next;
  logic [CLS_W-1:0]     cls, cls_next;
  logic [BW-1:0]        base, base_next;
  logic [SIZE_W-1:0]    req_q, req_q_next;
  logic [HANDLE_W-1:0]  hnd_q, hnd_q_next;
  logic [HANDLE_W-1:0]  res_handle, res_handle_next;
  status_t              res_status, res_status_next;
  logic                 out_valid_q, out_valid_next;
  logic [HANDLE_W-1:0]  handle_q, handle_q_next;
  status_t              status_q, status_q_next;

  logic [DW-1:0]        diff;
  logic [DW-1:0]        sum;
  logic                 at_last;
  logic                 in_class;
  logic                 slot_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state       <= state_next;
      out_valid_q <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    cls        <= cls_next;
    base       <= base_next;
    req_q      <= req_q_next;
    hnd_q      <= hnd_q_next;
    res_handle <= res_handle_next;
    res_status <= res_status_next;
    handle_q   <= handle_q_next;
    status_q   <= status_q_next;
  end

  always_comb begin
    diff     = DW'(hnd_q) - DW'(base);
    sum      = DW'(base) + DW'(pick);
    at_last  = (cls == CLS_W'(NUM_CLASSES - 1));
    in_class = diff < DW'(SLOTS_PER_CLASS);
    slot_ok  = diff < DW'(class_slots);

    state_next      = state;
    cls_next        = cls;
    base_next       = base;
    req_q_next      = req_q;
    hnd_q_next      = hnd_q;
    res_handle_next = res_handle;
    res_status_next = res_status;
    handle_q_next   = handle_q;
    status_q_next   = status_q;
    out_valid_next  = out_valid_q;
    map_op          = '0;
    wr_slot         = pick;

    if (out_valid_q && !out_stall) begin
      out_valid_next = 1'b0;
    end

    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cls_next   = '0;
          base_next  = '0;
          req_q_next = req_size[SIZE_W-1:0];
          hnd_q_next = free_handle;
          state_next = (cmd == CMD_FREE) ? S_FREE : S_FIND;
        end
      end
      S_FIND: begin
        res_handle_next = '0;
        if (req_q <= class_size) begin
          state_next = S_ALLOC;
        end else if (at_last) begin
          res_status_next = ST_TOO_LARGE;
          state_next      = S_RESULT;
        end else begin
          cls_next  = cls + CLS_W'(1);
          base_next = base + BW'(SLOTS_PER_CLASS);
        end
      end
      S_ALLOC: begin
        if (found) begin
          map_op.clr      = 1'b1;
          wr_slot         = pick;
          res_handle_next = sum[HANDLE_W-1:0];
          res_status_next = ST_OK;
          state_next      = S_RESULT;
        end else if (at_last) begin
          res_status_next = ST_NO_FREE;
          state_next      = S_RESULT;
        end else begin
          cls_next  = cls + CLS_W'(1);
          base_next = base + BW'(SLOTS_PER_CLASS);
        end
      end
      S_FREE: begin
        res_handle_next = '0;
        wr_slot         = diff[SLOT_W-1:0];
        if (in_class) begin
          if (slot_ok) begin
            map_op.set      = 1'b1;
            res_status_next = ST_OK;
          end else begin
            res_status_next = ST_BAD_HANDLE;
          end
          state_next = S_RESULT;
        end else if (at_last) begin
          res_status_next = ST_BAD_HANDLE;
          state_next      = S_RESULT;
        end else begin
          cls_next  = cls + CLS_W'(1);
          base_next = base + BW'(SLOTS_PER_CLASS);
        end
      end
      S_RESULT: begin
        if (!out_valid_q || !out_stall) begin
          handle_q_next  = res_handle;
          status_q_next  = res_status;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign rd_class      = cls;
  assign in_stall      = (state != S_IDLE);
  assign out_valid     = out_valid_q;
  assign buffer_handle = handle_q;
  assign status        = status_q;

endmodule

@@ rtl/core/size_class_buffer_pool_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// size_class_buffer_pool_top
// pool allocator for fixed-size buffers in size classes
// ----------------------------------------------------------------------------
// One item is worked at a time; in_stall stays high from acceptance until the
// result is loaded into the output register. A sequencer visits one class per
// cycle through a single compare/subtract unit and the class's free bitmap.
// An allocate steps through the classes in order to find the first one whose
// size covers the request, then searches that class and the classes after it
// for a free slot, and then loads the result. A free steps through the classes
// until the handle falls in one, checks the slot and loads the result. The
// output register lets the next item be accepted while a result still waits
// to be taken. No clearing pass follows reset.
// ----------------------------------------------------------------------------
module size_class_buffer_pool_top import scbp_pkg::*; #(
  parameter int NUM_CLASSES     = NUM_CLASSES_DEF,
  parameter int SLOTS_PER_CLASS = SLOTS_PER_CLASS_DEF,
  parameter int SIZE_BITS       = SIZE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  cmd,
  input  logic [REQ_W-1:0]      req_size,
  input  logic [HANDLE_W-1:0]   free_handle,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [HANDLE_W-1:0]   buffer_handle,
  output logic [STATUS_W-1:0]   status
);

  localparam int SIZE_W = (SIZE_BITS < REQ_W) ? SIZE_BITS : REQ_W;
  localparam int CLS_W  = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int SLOT_W = (SLOTS_PER_CLASS > 1) ? $clog2(SLOTS_PER_CLASS) : 1;
  localparam int CNT_W  = $clog2(SLOTS_PER_CLASS + 1);

  logic [CLS_W-1:0]  rd_class;
  logic [SIZE_W-1:0] class_size;
  logic [CNT_W-1:0]  class_slots;
  logic              found;
  logic [SLOT_W-1:0] pick;
  logic [SLOT_W-1:0] wr_slot;
  map_op_t           map_op;

  assign cfg_ready = 1'b1;

  scbp_cfg_regs #(
    .NUM_CLASSES     (NUM_CLASSES),
    .SLOTS_PER_CLASS (SLOTS_PER_CLASS),
    .SIZE_W          (SIZE_W)
  ) u_cfg_regs (
    .clk         (clk),
    .rst         (rst),
    .wr_en       (cfg_valid && cfg_ready),
    .wr_index    (cfg_index),
    .wr_data     (cfg_data),
    .rd_class    (rd_class),
    .class_size  (class_size),
    .class_slots (class_slots)
  );

  scbp_slot_map #(
    .NUM_CLASSES     (NUM_CLASSES),
    .SLOTS_PER_CLASS (SLOTS_PER_CLASS)
  ) u_slot_map (
    .clk         (clk),
    .rst         (rst),
    .rd_class    (rd_class),
    .class_slots (class_slots),
    .op          (map_op),
    .wr_slot     (wr_slot),
    .found       (found),
    .pick        (pick)
  );

  scbp_seq #(
    .NUM_CLASSES     (NUM_CLASSES),
    .SLOTS_PER_CLASS (SLOTS_PER_CLASS),
    .SIZE_W          (SIZE_W)
  ) u_seq (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .cmd           (cmd),
    .req_size      (req_size),
    .free_handle   (free_handle),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .buffer_handle (buffer_handle),
    .status        (status),
    .rd_class      (rd_class),
    .class_size    (class_size),
    .class_slots   (class_slots),
    .found         (found),
    .pick          (pick),
    .map_op        (map_op),
    .wr_slot       (wr_slot)
  );

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("block took a second item right after a transfer");

  a_fail_zero_handle: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> buffer_handle == '0)
    else $error("failed result carries a nonzero handle");

  a_result_after_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without an item in work");

  a_map_single_op: assert property (@(posedge clk) disable iff (rst)
    !(map_op.clr && map_op.set))
    else $error("slot map set and cleared in one cycle");
`endif

endmodule

@@ dv/size_class_buffer_pool_top_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// size_class_buffer_pool_top_test
// self-checking bench for the size-class buffer pool
// ----------------------------------------------------------------------------
// A directed table first walks the size limits, handle checks, double free and
// pool exhaustion at the reset settings. Random allocate/free traffic then runs
// under several register settings: ascending and unordered sizes, saturating,
// tiny and empty counts. Allocations mostly target class boundaries, frees
// mostly return live handles, and the rest is random noise. Each result
// transfer is compared with an in-bench pool model. Both sides idle at random.
// ----------------------------------------------------------------------------
module size_class_buffer_pool_top_test;
  import scbp_pkg::*;

  localparam int NCLS         = NUM_CLASSES_DEF;
  localparam int NSLOT        = SLOTS_PER_CLASS_DEF;
  localparam int DRAIN_CYCLES = 2 * NCLS + 8;
  localparam int PHASE_ITEMS  = 240;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    status_t             status;
  } pool_result_t;

  typedef struct {
    cmd_t                op;
    logic [REQ_W-1:0]    size;
    logic [HANDLE_W-1:0] hnd;
    bit                  typed;
    logic [HANDLE_W-1:0] exp_handle;
    status_t             exp_status;
  } dir_row_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_stall;
  logic                  cmd;
  logic [REQ_W-1:0]      req_size;
  logic [HANDLE_W-1:0]   free_handle;
  logic                  out_valid;
  logic                  out_stall;
  logic [HANDLE_W-1:0]   buffer_handle;
  logic [STATUS_W-1:0]   status;

  // pool model state
  logic [REQ_W-1:0]      cls_size [NCLS];
  logic [CFG_DATA_W-1:0] cls_counts;
  logic [NSLOT-1:0]      free_map [NCLS];

  pool_result_t        results_due [$];
  logic [HANDLE_W-1:0] live_handles [$];
  int                  errors = 0;
  int                  n_results = 0;
  int                  n_settings = 1;
  int                  status_hits [4] = '{0, 0, 0, 0};
  bit                  calm = 1'b0;

  dir_row_t dir_rows [24] = '{
    '{CMD_ALLOC, 16'd0,     7'd0,   1'b1, 7'd0,  ST_OK},
    '{CMD_ALLOC, 16'd50,    7'd0,   1'b1, 7'd1,  ST_OK},
    '{CMD_ALLOC, 16'd51,    7'd0,   1'b1, 7'd16, ST_OK},
    '{CMD_ALLOC, 16'd1024,  7'd0,   1'b1, 7'd80, ST_OK},
    '{CMD_ALLOC, 16'd1025,  7'd0,   1'b1, 7'd0,  ST_TOO_LARGE},
    '{CMD_ALLOC, 16'hFFFF,  7'h7F,  1'b1, 7'd0,  ST_TOO_LARGE},
    '{CMD_FREE,  16'd0,     7'h7F,  1'b1, 7'd0,  ST_BAD_HANDLE},
    '{CMD_FREE,  16'd0,     7'd96,  1'b1, 7'd0,  ST_BAD_HANDLE},
    '{CMD_FREE,  16'd0,     7'd5,   1'b1, 7'd0,  ST_BAD_HANDLE},
    '{CMD_FREE,  16'd0,     7'd15,  1'b1, 7'd0,  ST_BAD_HANDLE},
    '{CMD_FREE,  16'd0,     7'd1,   1'b1, 7'd0,  ST_OK},
    '{CMD_FREE,  16'd0,     7'd1,   1'b1, 7'd0,  ST_OK},
    '{CMD_ALLOC, 16'd1,     7'd0,   1'b1, 7'd1,  ST_OK},
    '{CMD_FREE,  16'd0,     7'd85,  1'b1, 7'd0,  ST_BAD_HANDLE},
    '{CMD_ALLOC, 16'd600,   7'd0,   1'b1, 7'd81, ST_OK},
    '{CMD_ALLOC, 16'd600,   7'd0,   1'b1, 7'd82, ST_OK},
    '{CMD_ALLOC, 16'd600,   7'd0,   1'b1, 7'd83, ST_OK},
    '{CMD_ALLOC, 16'd600,   7'd0,   1'b1, 7'd84, ST_OK},
    '{CMD_ALLOC, 16'd600,   7'd0,   1'b1, 7'd0,  ST_NO_FREE},
    '{CMD_ALLOC, 16'd400,   7'd0,   1'b1, 7'd64, ST_OK},
    '{CMD_FREE,  16'hFFFF,  7'd80,  1'b0, 7'd0,  ST_OK},
    '{CMD_ALLOC, 16'd700,   7'd0,   1'b0, 7'd0,  ST_OK},
    '{CMD_ALLOC, 16'd0,     7'h7F,  1'b0, 7'd0,  ST_OK},
    '{CMD_ALLOC, 16'd300,   7'd0,   1'b0, 7'd0,  ST_OK}
  };

  size_class_buffer_pool_top DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .cmd           (cmd),
    .req_size      (req_size),
    .free_handle   (free_handle),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .buffer_handle (buffer_handle),
    .status        (status)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int slots_in(int c);
    int n;
    n = cls_counts[COUNT_BITS*c +: COUNT_BITS];
    if (n > NSLOT) n = NSLOT;
    return n;
  endfunction

  // applies one command to the model pool and returns its result
  function automatic pool_result_t pool_apply(cmd_t op, logic [REQ_W-1:0] size,
                                              logic [HANDLE_W-1:0] hnd);
    pool_result_t r;
    int           first;
    int           c;
    int           s;
    bit           got;
    r.handle = '0;
    r.status = ST_OK;
    if (op == CMD_ALLOC) begin
      first = NCLS;
      for (c = NCLS - 1; c >= 0; c--) begin
        if (size <= cls_size[c]) first = c;
      end
      if (first == NCLS) begin
        r.status = ST_TOO_LARGE;
      end else begin
        got = 1'b0;
        for (c = first; c < NCLS; c++) begin
          for (s = 0; s < NSLOT; s++) begin
            if (!got && s < slots_in(c) && free_map[c][s]) begin
              free_map[c][s] = 1'b0;
              r.handle = HANDLE_W'(c * NSLOT + s);
              got = 1'b1;
            end
          end
        end
        if (!got) r.status = ST_NO_FREE;
      end
    end else begin
      c = int'(hnd) / NSLOT;
      s = int'(hnd) % NSLOT;
      if (c >= NCLS || s >= slots_in(c)) r.status = ST_BAD_HANDLE;
      else free_map[c][s] = 1'b1;
    end
    return r;
  endfunction

  task automatic send_item(cmd_t op, logic [REQ_W-1:0] size, logic [HANDLE_W-1:0] hnd,
                           bit typed, pool_result_t typed_res);
    int           gap;
    pool_result_t r;
    gap = calm ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    cmd         <= op;
    req_size    <= size;
    free_handle <= hnd;
    do @(posedge clk); while (in_stall !== 1'b0);
    r = pool_apply(op, size, hnd);
    if (op == CMD_ALLOC && r.status == ST_OK) live_handles.push_back(r.handle);
    results_due.push_back(typed ? typed_res : r);
  endtask

  task automatic idle_inputs();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    if (idx < SIZE_REGS) cls_size[idx] = val[REQ_W-1:0];
    else if (idx == REG_COUNTS) cls_counts = val;
  endtask

  task automatic load_settings(logic [NCLS-1:0][REQ_W-1:0] sizes,
                               logic [CFG_DATA_W-1:0] counts, bit poke_unused);
    int c;
    for (c = 0; c < NCLS; c++) write_reg(CFG_IDX_W'(c), CFG_DATA_W'(sizes[c]));
    if (poke_unused) write_reg(REG_UNUSED, '1);
    write_reg(REG_COUNTS, counts);
    cfg_valid <= 1'b0;
    n_settings++;
  endtask

  task automatic run_traffic(int n);
    int                  i;
    int                  k;
    int                  pick;
    int                  cls;
    bit                  filling;
    logic [REQ_W-1:0]    size;
    logic [HANDLE_W-1:0] hnd;
    pool_result_t        none;
    none    = '0;
    filling = 1'b1;
    for (i = 0; i < n; i++) begin
      calm = (i % 97) < 15;
      if (i % 40 == 0) filling = $urandom_range(0, 1);
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        // noise on every field
        send_item(cmd_t'($urandom_range(0, 1)), REQ_W'($urandom), HANDLE_W'($urandom),
                  1'b0, none);
      end else if (filling ? pick < 75 : pick < 35) begin
        cls = $urandom_range(0, NCLS - 1);
        case ($urandom_range(0, 3))
          0: size = cls_size[cls];
          1: size = cls_size[cls] + 1'b1;
          2: size = REQ_W'($urandom_range(0, cls_size[cls]));
          default: size = cls_size[cls] - 1'b1;
        endcase
        send_item(CMD_ALLOC, size, HANDLE_W'($urandom), 1'b0, none);
      end else if (live_handles.size() != 0) begin
        k   = $urandom_range(0, live_handles.size() - 1);
        hnd = live_handles[k];
        live_handles.delete(k);
        send_item(CMD_FREE, REQ_W'($urandom), hnd, 1'b0, none);
      end else begin
        send_item(CMD_FREE, REQ_W'($urandom),
                  HANDLE_W'($urandom_range(0, NCLS * NSLOT - 1)), 1'b0, none);
      end
    end
    calm = 1'b0;
  endtask

  // result side back-pressure
  initial begin
    int k;
    out_stall <= 1'b0;
    forever begin
      k = calm ? 0 : $urandom_range(0, 6);
      if (k > 0) begin
        out_stall <= 1'b1;
        repeat (k) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!(out_valid === 1'b1 && out_stall === 1'b0));
    end
  end

  always @(posedge clk) begin
    pool_result_t want;
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (results_due.size() == 0) begin
        $error("unexpected result transfer: buffer_handle %0d status %0d",
               buffer_handle, status);
        errors++;
      end else begin
        want = results_due.pop_front();
        n_results++;
        status_hits[want.status]++;
        if (buffer_handle !== want.handle) begin
          $error("buffer_handle: expected %0d, got %0d", want.handle, buffer_handle);
          errors++;
        end
        if (status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status);
          errors++;
        end
      end
    end
  end

  initial begin
    logic [NCLS-1:0][REQ_W-1:0] sizes;
    logic [CFG_DATA_W-1:0]      counts;
    pool_result_t               typed_res;
    int                         i;
    int                         c;
    rst         <= 1'b1;
    cfg_valid   <= 1'b0;
    cfg_index   <= '0;
    cfg_data    <= '0;
    in_valid    <= 1'b0;
    cmd         <= CMD_ALLOC;
    req_size    <= '0;
    free_handle <= '0;
    for (c = 0; c < NCLS; c++) begin
      cls_size[c] = SIZE_RESET[c];
      free_map[c] = '1;
    end
    cls_counts = COUNTS_RESET;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    for (i = 0; i < 24; i++) begin
      typed_res.handle = dir_rows[i].exp_handle;
      typed_res.status = dir_rows[i].exp_status;
      send_item(dir_rows[i].op, dir_rows[i].size, dir_rows[i].hnd, dir_rows[i].typed,
                typed_res);
    end
    run_traffic(PHASE_ITEMS);
    idle_inputs();

    // ascending sizes from 1 to the top, every count saturating
    sizes[0] = 16'd1;
    for (c = 1; c < NCLS; c++) sizes[c] = sizes[c-1] + REQ_W'($urandom_range(1, 8000));
    sizes[NCLS-1] = '1;
    load_settings(sizes, '1, 1'b1);
    run_traffic(PHASE_ITEMS);
    idle_inputs();

    // unordered sizes, raw counts
    for (c = 0; c < NCLS; c++) sizes[c] = REQ_W'($urandom_range(1, 65535));
    load_settings(sizes, CFG_DATA_W'($urandom), 1'b0);
    run_traffic(PHASE_ITEMS);
    idle_inputs();

    // smallest sizes, tiny pools with an empty first class
    for (c = 0; c < NCLS; c++) begin
      sizes[c] = 16'd1;
      counts[COUNT_BITS*c +: COUNT_BITS] = COUNT_BITS'($urandom_range(0, 2));
    end
    counts[COUNT_BITS-1:0] = '0;
    load_settings(sizes, counts, 1'b0);
    run_traffic(PHASE_ITEMS);
    idle_inputs();

    // ascending sizes, counts within range
    sizes[0] = REQ_W'($urandom_range(1, 200));
    for (c = 1; c < NCLS; c++) sizes[c] = sizes[c-1] + REQ_W'($urandom_range(0, 3000));
    for (c = 0; c < NCLS; c++)
      counts[COUNT_BITS*c +: COUNT_BITS] = COUNT_BITS'($urandom_range(0, NSLOT));
    load_settings(sizes, counts, 1'b0);
    run_traffic(PHASE_ITEMS);
    idle_inputs();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (results_due.size() != 0) begin
      $error("%0d results never arrived", results_due.size());
      errors++;
    end
    $display("pool run: %0d result transfers checked under %0d register settings",
             n_results, n_settings);
    $display("  ok %0d, too large %0d, no free buffer %0d, bad handle %0d",
             status_hits[ST_OK], status_hits[ST_TOO_LARGE], status_hits[ST_NO_FREE],
             status_hits[ST_BAD_HANDLE]);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
